// ===== design/cpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16/XMODEM byte step for the packet deframer.
// No dependencies; cpd_in_stage, cpd_core and the top level use this package.
package cpd_pkg;

    // Frame parsing phases.
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CRCH = 3'd3,
        PH_CRCL = 3'd4,
        PH_END  = 3'd5
    } t_phase;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [7:0]  START_SHORT = 8'h02;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'h0000;

    // One received byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_byte_item;

    // Advances a CRC-16/XMODEM over one byte, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/cpd_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the packet deframer: received bytes in, results out.
// No dependencies.
interface cpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cpd_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       frame_good;
    logic [7:0] frame_len;

    modport source (output valid, output out_kind, output out_byte, output frame_good,
                    output frame_len, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input frame_good,
                    input frame_len, output ready);
endinterface

// ===== design/cpd_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the packet deframer: captures one received byte per cycle while its item moves on.
// Depends on cpd_pkg and cpd_byte_if.
module cpd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cpd_byte_if.sink            i_rx,
    input  logic                i_take,
    output cpd_pkg::t_byte_item o_item
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // The register accepts a new item when empty or when its item moves on.
    assign i_rx.ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_rx.valid && i_rx.ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

// ===== design/cpd_core.sv =====
`timescale 1ns / 1ps
// Frame parser of the packet deframer: phase machine, running CRC and result register.
// Depends on cpd_pkg and cpd_res_if.
module cpd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpd_pkg::t_byte_item i_item,
    output logic                o_take,
    cpd_res_if.source           o_res
);

    cpd_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_recv, n_recv;

    logic        r_out_valid, n_out_valid;
    logic        r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic        r_good, n_good;
    logic [7:0]  r_flen, n_flen;

    logic        emit;
    logic [7:0]  cnt_inc;
    logic [7:0]  b;

    // An item is consumed when the result register is free or draining.
    assign o_take  = i_item.valid && (!r_out_valid || o_res.ready);
    assign b       = i_item.rx_byte;
    assign cnt_inc = r_count + 8'd1;

    // Next phase, frame state and result.
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_count = r_count;
        n_crc   = r_crc;
        n_recv  = r_recv;
        emit    = 1'b0;
        n_kind  = cpd_pkg::KIND_DATA;
        n_byte  = 8'h00;
        n_good  = 1'b0;
        n_flen  = 8'h00;
        if (o_take) begin
            case (r_phase)
                cpd_pkg::PH_LEN: begin
                    n_len   = b;
                    n_count = 8'h00;
                    n_crc   = cpd_pkg::CRC_INIT;
                    n_phase = (b == 8'h00) ? cpd_pkg::PH_CRCH : cpd_pkg::PH_DATA;
                end
                cpd_pkg::PH_DATA: begin
                    n_crc   = cpd_pkg::crc_step(r_crc, b);
                    n_count = cnt_inc;
                    if (cnt_inc == r_len) begin
                        n_phase = cpd_pkg::PH_CRCH;
                    end
                    emit   = 1'b1;
                    n_kind = cpd_pkg::KIND_DATA;
                    n_byte = b;
                end
                cpd_pkg::PH_CRCH: begin
                    n_recv  = {b, 8'h00};
                    n_phase = cpd_pkg::PH_CRCL;
                end
                cpd_pkg::PH_CRCL: begin
                    n_recv  = {r_recv[15:8], b};
                    n_phase = cpd_pkg::PH_END;
                end
                cpd_pkg::PH_END: begin
                    n_phase = cpd_pkg::PH_HUNT;
                    emit    = 1'b1;
                    n_kind  = cpd_pkg::KIND_REPORT;
                    n_good  = (r_crc == r_recv);
                    n_flen  = r_len;
                end
                default: begin
                    // Hunting: anything but a short-frame start byte is dropped.
                    n_phase = (b == cpd_pkg::START_SHORT) ? cpd_pkg::PH_LEN
                                                          : cpd_pkg::PH_HUNT;
                end
            endcase
        end
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cpd_pkg::PH_HUNT;
            r_len       <= 8'h00;
            r_count     <= 8'h00;
            r_crc       <= cpd_pkg::CRC_INIT;
            r_recv      <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_recv      <= n_recv;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register, loaded only when a result is produced.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_good <= n_good;
            r_flen <= n_flen;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_kind   = r_kind;
    assign o_res.out_byte   = r_byte;
    assign o_res.frame_good = r_good;
    assign o_res.frame_len  = r_flen;

    // A payload result never carries report fields.
    a_data_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == cpd_pkg::KIND_DATA) |-> (r_good == 1'b0 && r_flen == 8'h00))
        else $error("payload result carries report fields");

    // Consuming the end byte always yields a report in the next cycle.
    a_end_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == cpd_pkg::PH_END) |=> (r_out_valid && r_kind == cpd_pkg::KIND_REPORT))
        else $error("end byte did not produce a report");

    // While in the payload phase fewer bytes have been taken than the length.
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cpd_pkg::PH_DATA) |-> (r_count < r_len))
        else $error("payload count reached length inside payload phase");

endmodule

// ===== design/crc16_packet_deframer.sv =====
`timescale 1ns / 1ps
// CRC-16/XMODEM short-frame deframer: one received byte in, at most one result out.
// An accepted byte is held in the input register; a result it yields is held in the result register.
// Throughput: one byte per cycle while the receiver keeps up; a waiting result holds the input.
// Reset (synchronous, active low) returns to hunting for a start byte and empties both registers.
// Depends on cpd_pkg, cpd_ifs, cpd_in_stage and cpd_core.
module crc16_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpd_byte_if.sink   i_rx,
    cpd_res_if.source  o_res
);

    cpd_pkg::t_byte_item item;
    logic                take;

    cpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_item  (item)
    );

    cpd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule
